@@ rtl/core/sma_pkg.sv @@
`default_nettype none
package sma_pkg;

   localparam int MEMORY_BYTES_DEF    = 16384;
   localparam int SEGMENT_ENTRIES_DEF = 8;

   localparam logic [1:0] KIND_TABLE   = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_WRITE   = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   localparam int BANKS = 4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] segment;
      logic [15:0] offset;
      logic [2:0]  num_bytes;
      logic [31:0] write_value;
      logic [15:0] entry_base;
      logic [15:0] entry_size;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [15:0] physical_address;
      logic        fault;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic access;
      logic finish;
   } ctl_cmd_type;

endpackage
`default_nettype wire

@@ rtl/core/sma_ctrl.sv @@
`default_nettype none
module sma_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output sma_pkg::ctl_cmd_type     cmd
);

   sma_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sma_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         sma_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sma_pkg::ST_ACCESS;
            end
         end
         sma_pkg::ST_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = sma_pkg::ST_FINISH;
         end
         sma_pkg::ST_FINISH: begin
            // output register must be free or draining this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = sma_pkg::ST_IDLE;
            end
         end
         default: state_in = sma_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ rtl/core/sma_datapath.sv @@
`default_nettype none
module sma_datapath #(
   parameter int MEMORY_BYTES    = sma_pkg::MEMORY_BYTES_DEF,
   parameter int SEGMENT_ENTRIES = sma_pkg::SEGMENT_ENTRIES_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  sma_pkg::ctl_cmd_type     cmd,
   input  sma_pkg::req_type         req_payload,
   output sma_pkg::rsp_type         rsp_payload
);

   localparam int IDX_W  = (SEGMENT_ENTRIES > 1) ? $clog2(SEGMENT_ENTRIES) : 1;
   localparam int ADDR_W = $clog2(MEMORY_BYTES);
   localparam int ROWS   = (MEMORY_BYTES + sma_pkg::BANKS - 1) / sma_pkg::BANKS;
   localparam int ROW_W  = ADDR_W - 2;
   localparam logic [17:0] MEM_LIMIT = 18'(MEMORY_BYTES);
   localparam logic [15:0] SEG_LIMIT = 16'(SEGMENT_ENTRIES);

   // segment table
   logic [15:0] tbl_base_ff [SEGMENT_ENTRIES];
   logic [15:0] tbl_size_ff [SEGMENT_ENTRIES];

   // request state held through the access
   logic [1:0]        kind_ff;
   logic              fault_ff;
   logic [ADDR_W-1:0] phys_ff;
   logic [2:0]        count_ff;
   logic [31:0]       value_ff;

   logic [7:0]        rdata_ff [sma_pkg::BANKS];
   sma_pkg::rsp_type  rsp_ff, rsp_in;

   // lookup and limit checks in the accept cycle
   logic             seg_ok, count_ok, seg_fault, mem_fault, fault_in;
   logic [IDX_W-1:0] seg_idx;
   logic [15:0]      base, size;
   logic [16:0]      seg_end, phys_sum;
   logic [17:0]      phys_end;

   always_comb begin
      seg_ok   = req_payload.segment < SEG_LIMIT;
      seg_idx  = seg_ok ? req_payload.segment[IDX_W-1:0] : '0;
      base     = tbl_base_ff[seg_idx];
      size     = tbl_size_ff[seg_idx];
      count_ok = (req_payload.num_bytes >= 3'd1) && (req_payload.num_bytes <= 3'd4);
      seg_end  = {1'b0, req_payload.offset} + 17'(req_payload.num_bytes);
      phys_sum = {1'b0, base} + {1'b0, req_payload.offset};
      phys_end = {2'b00, base} + {2'b00, req_payload.offset}
                 + 18'(req_payload.num_bytes);
      seg_fault = seg_end > {1'b0, size};
      mem_fault = phys_end > MEM_LIMIT;
      case (req_payload.kind)
         sma_pkg::KIND_TABLE: fault_in = !seg_ok;
         sma_pkg::KIND_READ,
         sma_pkg::KIND_WRITE: fault_in = !seg_ok || !count_ok || seg_fault || mem_fault;
         default:             fault_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < SEGMENT_ENTRIES; e++) begin
            tbl_base_ff[e] <= '0;
            tbl_size_ff[e] <= '0;
         end
      end else if (cmd.accept && req_payload.kind == sma_pkg::KIND_TABLE && seg_ok) begin
         tbl_base_ff[seg_idx] <= req_payload.entry_base;
         tbl_size_ff[seg_idx] <= req_payload.entry_size;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff  <= req_payload.kind;
         fault_ff <= fault_in;
         phys_ff  <= phys_sum[ADDR_W-1:0];
         count_ff <= req_payload.num_bytes;
         value_ff <= req_payload.write_value;
      end
   end

   // four byte banks, interleaved on the low address bits
   for (genvar k = 0; k < sma_pkg::BANKS; k++) begin : g_bank
      logic [7:0]        mem [ROWS];
      logic [1:0]        lane;
      logic [1:0]        shift;
      logic              lane_en, we;
      logic [ADDR_W-1:0] addr;
      logic [ROW_W-1:0]  row;
      logic [31:0]       shifted;

      always_comb begin
         // byte position within the access that lands in this bank
         lane    = 2'(k) - phys_ff[1:0];
         lane_en = {1'b0, lane} < count_ff;
         addr    = phys_ff + ADDR_W'(lane);
         row     = addr[ADDR_W-1:2];
         shift   = 2'(count_ff - 3'd1 - {1'b0, lane});
         shifted = value_ff >> {shift, 3'b000};
         we      = cmd.access && kind_ff == sma_pkg::KIND_WRITE && !fault_ff && lane_en;
      end

      always_ff @(posedge clock) begin
         if (we) begin
            mem[row] <= shifted[7:0];
         end
         if (cmd.access) begin
            rdata_ff[k] <= mem[row];
         end
      end
   end

   // big-endian assembly of the read bytes
   logic [31:0] data;
   logic [1:0]  bank_sel;

   always_comb begin
      data     = '0;
      bank_sel = '0;
      for (int i = 0; i < sma_pkg::BANKS; i++) begin
         bank_sel = phys_ff[1:0] + 2'(i);
         if (3'(i) < count_ff) begin
            data = {data[23:0], rdata_ff[bank_sel]};
         end
      end
      rsp_in.fault = fault_ff;
      rsp_in.read_data = (kind_ff == sma_pkg::KIND_READ && !fault_ff) ? data : '0;
      rsp_in.physical_address = (fault_ff || kind_ff == sma_pkg::KIND_TABLE)
                                ? '0 : 16'(phys_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/core/segmented_memory_access.sv @@
// sequence: after the request beat is accepted, the lookup, the bank access and the result
//    load follow in turn; the load waits while the previous result beat awaits rsp_ready
// throughput: a new request is not taken before the last result is loaded, since
//    req_ready stays low until the result is loaded
// reset: synchronous, clears the controller, the result valid and all
//    segment table entries; byte memory is not initialized
`default_nettype none
module segmented_memory_access #(
   parameter int MEMORY_BYTES    = sma_pkg::MEMORY_BYTES_DEF,
   parameter int SEGMENT_ENTRIES = sma_pkg::SEGMENT_ENTRIES_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  sma_pkg::req_type     req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output sma_pkg::rsp_type     rsp_payload
);

   sma_pkg::ctl_cmd_type cmd;

   sma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sma_datapath #(
      .MEMORY_BYTES    (MEMORY_BYTES),
      .SEGMENT_ENTRIES (SEGMENT_ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

@@ rtl/core/sma_checker.sv @@
`default_nettype none
module sma_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input sma_pkg::req_type  req_payload,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input sma_pkg::rsp_type  rsp_payload
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response beat changed");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.fault |->
         rsp_payload.read_data == 32'd0 && rsp_payload.physical_address == 16'd0)
      else $error("faulted beat carries data or address");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

endmodule

bind segmented_memory_access sma_checker u_sma_checker (.*);
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

   localparam int MEM_BYTES   = sma_pkg::MEMORY_BYTES_DEF;
   localparam int SEG_ENTRIES = sma_pkg::SEGMENT_ENTRIES_DEF;
   localparam int SEG_IDX_W   = (SEG_ENTRIES > 1) ? $clog2(SEG_ENTRIES) : 1;

   typedef struct {
      sma_pkg::req_type item;
      bit               typed;
      sma_pkg::rsp_type golden;
   } dir_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   sma_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   sma_pkg::rsp_type rsp_payload;

   // shadow of the segment table and byte memory
   bit [31:0]  seg_table [SEG_ENTRIES];
   logic [7:0] mem_image [MEM_BYTES];
   bit         mem_written [MEM_BYTES];

   sma_pkg::rsp_type awaited_results [$];
   dir_row_type      directed_rows [$];
   int               mismatch_count;
   int               send_idle_pct;
   int               stall_pct;
   bit               hold_armed;

   segmented_memory_access u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic sma_pkg::rsp_type translate_access(input sma_pkg::req_type item);
      sma_pkg::rsp_type     res;
      int unsigned          base, limit, phys, cnt, i;
      logic [31:0]          data;
      logic [SEG_IDX_W-1:0] idx;
      res = '0;
      data = '0;
      cnt = 32'(item.num_bytes);
      idx = item.segment[SEG_IDX_W-1:0];
      if (item.kind == sma_pkg::KIND_TABLE) begin
         if (item.segment < SEG_ENTRIES)
            seg_table[idx] = {item.entry_base, item.entry_size};
         else
            res.fault = 1'b1;
      end else if (item.kind == sma_pkg::KIND_INVALID || cnt < 1 || cnt > 4 ||
                   item.segment >= SEG_ENTRIES) begin
         res.fault = 1'b1;
      end else begin
         base = 32'(seg_table[idx][31:16]);
         limit = 32'(seg_table[idx][15:0]);
         phys = base + 32'(item.offset);
         if (32'(item.offset) + cnt > limit || phys + cnt > MEM_BYTES) begin
            res.fault = 1'b1;
         end else begin
            for (i = 0; i < cnt; i++) begin
               if (item.kind == sma_pkg::KIND_WRITE) begin
                  mem_image[phys + i] = 8'(item.write_value >> (8 * (cnt - 1 - i)));
                  mem_written[phys + i] = 1'b1;
               end else begin
                  data = {data[23:0], mem_image[phys + i]};
               end
            end
            res.read_data = data;
            res.physical_address = phys[15:0];
         end
      end
      return res;
   endfunction

   function automatic sma_pkg::req_type mk_req(input logic [1:0] kind,
                                               input logic [15:0] seg,
                                               input logic [15:0] off,
                                               input logic [2:0] cnt,
                                               input logic [31:0] val,
                                               input logic [15:0] base,
                                               input logic [15:0] size);
      sma_pkg::req_type item;
      item.kind = kind;
      item.segment = seg;
      item.offset = off;
      item.num_bytes = cnt;
      item.write_value = val;
      item.entry_base = base;
      item.entry_size = size;
      return item;
   endfunction

   function automatic sma_pkg::rsp_type mk_rsp(input logic [31:0] data,
                                               input logic [15:0] addr,
                                               input logic flt);
      sma_pkg::rsp_type res;
      res.read_data = data;
      res.physical_address = addr;
      res.fault = flt;
      return res;
   endfunction

   function automatic sma_pkg::req_type make_random_item();
      sma_pkg::req_type     item;
      int unsigned          pick, variant, base, limit, cnt, i;
      bit                   hits_blank;
      logic [SEG_IDX_W-1:0] idx;
      hits_blank = 1'b0;
      pick = $urandom_range(99);
      item.kind = sma_pkg::KIND_READ;
      item.segment = 16'($urandom);
      item.offset = 16'($urandom);
      item.num_bytes = 3'($urandom_range(7));
      item.write_value = $urandom;
      item.entry_base = 16'($urandom);
      item.entry_size = 16'($urandom);
      if (pick < 10) begin
         item.kind = sma_pkg::KIND_TABLE;
         if ($urandom_range(9) != 0)
            item.segment = 16'($urandom_range(SEG_ENTRIES));
         variant = $urandom_range(9);
         if (variant == 1) begin
            item.entry_size = '0;
         end else if (variant == 2 || variant == 3) begin
            // segment hugging the top of memory, sometimes hanging over it
            item.entry_size = 16'($urandom_range(1, 48));
            item.entry_base = 16'(MEM_BYTES - $urandom_range(1, 64));
         end else if (variant > 3) begin
            // small windows near the bottom so reads find written bytes
            item.entry_base = 16'($urandom_range(0, 160));
            item.entry_size = 16'($urandom_range(1, 96));
         end
      end else if (pick < 16) begin
         item.kind = 2'($urandom_range(3));
      end else begin
         item.kind = ($urandom_range(99) < 55) ? sma_pkg::KIND_READ : sma_pkg::KIND_WRITE;
         if ($urandom_range(19) != 0)
            item.segment = 16'($urandom_range(0, SEG_ENTRIES - 1));
         if ($urandom_range(15) != 0)
            item.num_bytes = 3'($urandom_range(1, 4));
         idx = item.segment[SEG_IDX_W-1:0];
         if ($urandom_range(15) != 0 && item.segment < SEG_ENTRIES)
            item.offset = 16'($urandom_range(0, 32'(seg_table[idx][15:0]) + 1));
      end
      // a read that would succeed on bytes never stored becomes a write
      cnt = 32'(item.num_bytes);
      idx = item.segment[SEG_IDX_W-1:0];
      if (item.kind == sma_pkg::KIND_READ && item.segment < SEG_ENTRIES &&
          cnt >= 1 && cnt <= 4) begin
         base = 32'(seg_table[idx][31:16]);
         limit = 32'(seg_table[idx][15:0]);
         if (32'(item.offset) + cnt <= limit &&
             base + 32'(item.offset) + cnt <= MEM_BYTES) begin
            for (i = 0; i < cnt; i++)
               if (!mem_written[base + 32'(item.offset) + i])
                  hits_blank = 1'b1;
         end
      end
      if (hits_blank)
         item.kind = sma_pkg::KIND_WRITE;
      return item;
   endfunction

   task automatic add_row(input sma_pkg::req_type item, input bit typed,
                          input sma_pkg::rsp_type golden);
      dir_row_type row;
      row.item = item;
      row.typed = typed;
      row.golden = golden;
      directed_rows.push_back(row);
   endtask

   task automatic send_beat(input sma_pkg::req_type item, input bit typed,
                            input sma_pkg::rsp_type golden);
      sma_pkg::rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = translate_access(item);
      awaited_results.push_back(typed ? golden : predicted);
   endtask

   task automatic run_random(input int beats, input int send_pct, input int hold_pct);
      send_idle_pct = send_pct;
      stall_pct = hold_pct;
      repeat (beats)
         send_beat(make_random_item(), 1'b0, '0);
   endtask

   // receiver: random stalls, plus one long hold-off when armed
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 80;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin : result_check
      sma_pkg::rsp_type golden;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $error("result beat with nothing outstanding: %h", rsp_payload);
            mismatch_count++;
         end else begin
            golden = awaited_results.pop_front();
            if (rsp_payload.read_data !== golden.read_data) begin
               $error("read_data: expected %h, got %h", golden.read_data,
                      rsp_payload.read_data);
               mismatch_count++;
            end
            if (rsp_payload.physical_address !== golden.physical_address) begin
               $error("physical_address: expected %h, got %h", golden.physical_address,
                      rsp_payload.physical_address);
               mismatch_count++;
            end
            if (rsp_payload.fault !== golden.fault) begin
               $error("fault: expected %b, got %b", golden.fault, rsp_payload.fault);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      mismatch_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_armed = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // access to a zero-size segment right after reset
      add_row(mk_req(sma_pkg::KIND_READ, 16'd0, 16'd0, 3'd4, '0, '0, '0), 1'b1,
              mk_rsp('0, '0, 1'b1));
      // table index out of range
      add_row(mk_req(sma_pkg::KIND_TABLE, 16'd8, 16'd0, 3'd1, '0, 16'h1234, 16'h0010),
              1'b1, mk_rsp('0, '0, 1'b1));
      add_row(mk_req(sma_pkg::KIND_TABLE, 16'hFFFF, 16'hFFFF, 3'd7, '1, 16'hFFFF,
                     16'hFFFF), 1'b1, mk_rsp('0, '0, 1'b1));
      add_row(mk_req(sma_pkg::KIND_TABLE, 16'd0, 16'd0, 3'd0, '0, 16'h0000, 16'hFFFF),
              1'b1, mk_rsp('0, '0, 1'b0));
      add_row(mk_req(sma_pkg::KIND_TABLE, 16'd7, 16'd0, 3'd0, '0, 16'h3FFC, 16'h0004),
              1'b1, mk_rsp('0, '0, 1'b0));
      add_row(mk_req(sma_pkg::KIND_TABLE, 16'd1, 16'd0, 3'd0, '0, 16'hFFFF, 16'hFFFF),
              1'b1, mk_rsp('0, '0, 1'b0));
      add_row(mk_req(sma_pkg::KIND_TABLE, 16'd3, 16'd0, 3'd0, '0, 16'h0000, 16'h0000),
              1'b1, mk_rsp('0, '0, 1'b0));
      add_row(mk_req(sma_pkg::KIND_WRITE, 16'd0, 16'd0, 3'd4, 32'hFFFF_FFFF, '0, '0),
              1'b1, mk_rsp('0, '0, 1'b0));
      add_row(mk_req(sma_pkg::KIND_READ, 16'd0, 16'd0, 3'd4, '0, '0, '0), 1'b1,
              mk_rsp(32'hFFFF_FFFF, '0, 1'b0));
      add_row(mk_req(sma_pkg::KIND_WRITE, 16'd7, 16'd0, 3'd4, 32'h1234_5678, '0, '0),
              1'b1, mk_rsp('0, 16'h3FFC, 1'b0));
      add_row(mk_req(sma_pkg::KIND_READ, 16'd7, 16'd0, 3'd4, '0, '0, '0), 1'b1,
              mk_rsp(32'h1234_5678, 16'h3FFC, 1'b0));
      // runs past the segment limit, then reads the last byte inside it
      add_row(mk_req(sma_pkg::KIND_READ, 16'd7, 16'd1, 3'd4, '0, '0, '0), 1'b1,
              mk_rsp('0, '0, 1'b1));
      add_row(mk_req(sma_pkg::KIND_READ, 16'd7, 16'd3, 3'd1, '0, '0, '0), 1'b1,
              mk_rsp(32'h0000_0078, 16'h3FFF, 1'b0));
      // runs past the end of memory, then a zero-size segment, segment indices out of range and an invalid kind
      add_row(mk_req(sma_pkg::KIND_READ, 16'd1, 16'd0, 3'd1, '0, '0, '0), 1'b1,
              mk_rsp('0, '0, 1'b1));
      add_row(mk_req(sma_pkg::KIND_READ, 16'd3, 16'd0, 3'd1, '0, '0, '0), 1'b1,
              mk_rsp('0, '0, 1'b1));
      add_row(mk_req(sma_pkg::KIND_READ, 16'd8, 16'd0, 3'd1, '0, '0, '0), 1'b1,
              mk_rsp('0, '0, 1'b1));
      add_row(mk_req(sma_pkg::KIND_WRITE, 16'hFFFF, 16'd0, 3'd1, '1, '0, '0), 1'b1,
              mk_rsp('0, '0, 1'b1));
      add_row(mk_req(sma_pkg::KIND_INVALID, 16'd0, 16'd0, 3'd1, '1, '1, '1), 1'b1,
              mk_rsp('0, '0, 1'b1));
      // byte counts outside one to four, then an offset past the segment limit
      add_row(mk_req(sma_pkg::KIND_READ, 16'd0, 16'd0, 3'd0, '0, '0, '0), 1'b1,
              mk_rsp('0, '0, 1'b1));
      add_row(mk_req(sma_pkg::KIND_READ, 16'd0, 16'd0, 3'd7, '0, '0, '0), 1'b1,
              mk_rsp('0, '0, 1'b1));
      add_row(mk_req(sma_pkg::KIND_WRITE, 16'd0, 16'd0, 3'd5, '1, '0, '0), 1'b1,
              mk_rsp('0, '0, 1'b1));
      add_row(mk_req(sma_pkg::KIND_WRITE, 16'd0, 16'hFFFF, 3'd1, '1, '0, '0), 1'b1,
              mk_rsp('0, '0, 1'b1));
      add_row(mk_req(sma_pkg::KIND_TABLE, 16'd2, 16'd0, 3'd0, '0, 16'h0040, 16'h0020),
              1'b0, '0);
      add_row(mk_req(sma_pkg::KIND_WRITE, 16'd2, 16'd5, 3'd3, $urandom, '0, '0), 1'b0, '0);
      add_row(mk_req(sma_pkg::KIND_READ, 16'd2, 16'd5, 3'd2, '0, '0, '0), 1'b0, '0);
      add_row(mk_req(sma_pkg::KIND_READ, 16'd2, 16'd6, 3'd2, '0, '0, '0), 1'b0, '0);

      foreach (directed_rows[i])
         send_beat(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].golden);

      run_random(150, 0, 0);
      // receiver holds off while the sender keeps pushing
      hold_armed = 1'b1;
      run_random(50, 0, 0);
      hold_armed = 1'b0;
      run_random(150, 56, 0);
      run_random(150, 0, 56);
      run_random(150, 21, 21);
      req_valid <= 1'b0;

      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
